[src/slxfr_pkg.sv]
// Shared constants and controller/datapath interface types for the frame receiver.
package slxfr_pkg;

	// Size of the frame buffer in bytes and the count added to the length byte.
	localparam int BUFFER_BYTES   = 32;
	localparam int FRAME_OVERHEAD = 3;

	// Buffer index width; every frame position fits in it.
	localparam int ADDR_W = $clog2(BUFFER_BYTES);

	// Width of length plus overhead, wide enough for 255 + 3.
	localparam int FIN_W = 9;

	localparam logic [7:0]        SYNC_RESET  = 8'd164;
	localparam logic [ADDR_W-1:0] FINAL_RESET = ADDR_W'(2);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_byte;   // an input byte transfers this cycle
		logic start_emit;  // the byte completes a good frame
		logic load_out;    // load the buffer read data into the output register
		logic next_idx;    // step the readout index
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic good_end;   // the current input byte would end a frame with zero checksum
		logic out_free;   // the output register can take a byte this cycle
		logic idx_last;   // the readout index points at the final byte to emit
	} dp_status_t;

endpackage

[src/sync_length_xor_frame_receiver.sv]
// Top level of the sync, length and XOR checksum frame receiver.
// Takes one received byte per input transfer and emits the length, id and payload bytes
// of each frame whose XOR checksum comes out zero, with frame_last on the final one.
// While no good frame is being read out, a byte is taken every cycle. When the checksum
// byte of a good frame arrives, the n stored bytes are read from the single-port-read
// frame buffer one at a time, each by a buffer read and then an output register load,
// and each load waits until the output register is free; no input is taken meanwhile.
// The last byte sits in the output register while input is already taken again.
// Frames whose length plus overhead reaches the buffer size are dropped; bad frames
// produce nothing. No clearing pass runs after reset.
module sync_length_xor_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_last
);

	import slxfr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// Sequencing of byte intake and frame readout.
	slxfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Position, checksum, buffer and output register.
	slxfr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx_byte     (rx_byte),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

endmodule

[src/slxfr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module slxfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and read ports; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[src/slxfr_dp.sv]
// Datapath: frame position tracking, checksum, frame buffer and output register.
module slxfr_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  logic [7:0]             rx_byte,
	input  logic                   out_ready,
	input  slxfr_pkg::ctrl_cmd_t   cmd,
	output slxfr_pkg::dp_status_t  sts,
	output logic                   out_valid,
	output logic [7:0]             frame_byte,
	output logic                   frame_last
);

	import slxfr_pkg::*;

	logic [7:0]        sync_q;
	logic [ADDR_W-1:0] write_pos_q;
	logic [ADDR_W-1:0] final_pos_q;
	logic [7:0]        xor_q;
	logic [ADDR_W-1:0] emit_idx_q;
	logic [ADDR_W-1:0] emit_end_q;
	logic              out_valid_q;
	logic [7:0]        frame_byte_q;
	logic              frame_last_q;

	logic [7:0]        xor_next;
	logic [FIN_W-1:0]  fin;
	logic              too_long;
	logic              is_sync;
	logic              at_final;
	logic [7:0]        rd_data;
	logic              ram_we;

	// Byte classification for the current input.
	assign xor_next = xor_q ^ rx_byte;
	assign fin      = FIN_W'(rx_byte) + FIN_W'(FRAME_OVERHEAD);
	assign too_long = (fin >= FIN_W'(BUFFER_BYTES));
	assign is_sync  = (rx_byte == sync_q);
	assign at_final = (write_pos_q >= final_pos_q);

	// Status toward the controller.
	assign sts.good_end = (write_pos_q >= ADDR_W'(2)) && at_final && (xor_next == 8'd0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.idx_last = ((emit_idx_q + ADDR_W'(1)) == emit_end_q);

	// Sync byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

	// Frame position, final position and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			final_pos_q <= FINAL_RESET;
			xor_q       <= 8'd0;
		end else if (cmd.take_byte) begin
			if (write_pos_q == '0) begin
				// Hunting: a sync byte opens a frame.
				if (is_sync) begin
					xor_q       <= rx_byte;
					final_pos_q <= FINAL_RESET;
					write_pos_q <= ADDR_W'(1);
				end
			end else if (write_pos_q == ADDR_W'(1)) begin
				// Length byte: check that the frame fits the buffer.
				if (too_long) begin
					if (is_sync) begin
						xor_q       <= rx_byte;
						final_pos_q <= FINAL_RESET;
						write_pos_q <= ADDR_W'(1);
					end else begin
						xor_q       <= xor_next;
						write_pos_q <= '0;
					end
				end else begin
					xor_q       <= xor_next;
					final_pos_q <= fin[ADDR_W-1:0];
					write_pos_q <= ADDR_W'(2);
				end
			end else begin
				// Body bytes up to and including the checksum byte.
				xor_q <= xor_next;
				if (at_final) begin
					write_pos_q <= '0;
				end else begin
					write_pos_q <= write_pos_q + ADDR_W'(1);
				end
			end
		end
	end

	// Readout index and end marker for a good frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
			emit_end_q <= '0;
		end else if (cmd.start_emit) begin
			emit_idx_q <= ADDR_W'(1);
			emit_end_q <= write_pos_q;
		end else if (cmd.next_idx) begin
			emit_idx_q <= emit_idx_q + ADDR_W'(1);
		end
	end

	// Every byte after the sync byte goes into the buffer at its position.
	assign ram_we = cmd.take_byte && (write_pos_q != '0);

	slxfr_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (write_pos_q),
		.wr_data (rx_byte),
		.rd_addr (emit_idx_q),
		.rd_data (rd_data)
	);

	// Output register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			frame_byte_q <= rd_data;
			frame_last_q <= sts.idx_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_last = frame_last_q;

	// The checksum position always lies inside the buffer.
	a_final_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		32'(final_pos_q) < BUFFER_BYTES)
		else $error("final position outside the buffer");

	// Readout never loads the sync byte or the checksum byte.
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (emit_idx_q != '0) && (emit_idx_q < emit_end_q))
		else $error("readout index outside the frame");

	// A load never overwrites a result that is still waiting.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before transfer");

endmodule

[src/slxfr_ctrl.sv]
// Controller: accepts input bytes and sequences the readout of a good frame.
module slxfr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  slxfr_pkg::dp_status_t  sts,
	output logic                   in_ready,
	output slxfr_pkg::ctrl_cmd_t   cmd
);

	import slxfr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Commands decoded from the state and handshakes.
	assign in_ready       = (state_q == ST_IDLE);
	assign cmd.take_byte  = in_valid && in_ready;
	assign cmd.start_emit = cmd.take_byte && sts.good_end;
	assign cmd.load_out   = (state_q == ST_LOAD) && sts.out_free;
	assign cmd.next_idx   = cmd.load_out && !sts.idx_last;

	// Next state: one buffer read, then one load per emitted byte.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start_emit) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (cmd.load_out) begin
					state_d = sts.idx_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A good frame end always starts a readout.
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_emit |=> state_q == ST_READ)
		else $error("good frame did not start readout");

	// After a byte that is not the last, the next buffer read follows.
	a_next_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && !sts.idx_last |=> state_q == ST_READ)
		else $error("readout stopped early");

	// The final load returns the receiver to taking bytes.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && sts.idx_last |=> in_ready)
		else $error("receiver did not return to idle");

endmodule

[sim/sync_length_xor_frame_receiver_test.sv]
// Self-checking testbench for the sync, length and XOR checksum frame receiver.
module sync_length_xor_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slxfr_pkg::*;

	typedef logic [7:0] byte_t;
	typedef byte_t byte_queue_t[$];

	typedef struct packed {
		byte_t data;
		logic  last;
	} frame_out_t;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int MAX_REPORTS     = 50;

	logic  clk;
	logic  arst_n;
	logic  cfg_wr_en;
	byte_t cfg_wr_data;
	logic  in_valid;
	logic  in_ready;
	byte_t rx_byte;
	logic  out_valid;
	logic  out_ready;
	byte_t frame_byte;
	logic  frame_last;

	// Receiver state as the testbench tracks it.
	byte_t track_sync;
	int    track_index;
	int    track_final;
	byte_t track_xor;
	byte_t track_store [BUFFER_BYTES];

	frame_out_t expected_frame_bytes[$];
	int         mismatch_count;
	int         frame_bytes_sent;
	bit         sender_gaps;
	bit         receiver_stalls;
	bit         hold_off_request;

	sync_length_xor_frame_receiver DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

	// Free-running clock, 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Start of a frame: the sync byte seeds the checksum.
	function automatic void track_begin_frame(input byte_t b);
		track_store[0] = b;
		track_xor = b;
		track_final = 2;
		track_index = 1;
	endfunction

	// Advance the tracked state by one received byte and queue any frame bytes it releases.
	function automatic void absorb_rx_byte(input byte_t b);
		int         last_index;
		frame_out_t item;
		if (track_index == 0) begin
			if (b == track_sync)
				track_begin_frame(b);
		end else if (track_index == 1) begin
			last_index = int'(b) + FRAME_OVERHEAD;
			track_store[1] = b;
			track_xor ^= b;
			if (last_index >= BUFFER_BYTES) begin
				// Length too large: resync on a sync-valued length byte, else hunt.
				if (b == track_sync)
					track_begin_frame(b);
				else
					track_index = 0;
			end else begin
				track_final = last_index;
				track_index = 2;
			end
		end else begin
			track_store[track_index] = b;
			track_xor ^= b;
			if (track_index >= track_final) begin
				if (track_xor == 8'h00) begin
					for (int i = 1; i < track_index; i++) begin
						item.data = track_store[i];
						item.last = (i + 1 == track_index);
						expected_frame_bytes.push_back(item);
					end
				end
				track_index = 0;
			end else begin
				track_index++;
			end
		end
	endfunction

	// One input transfer; valid stays high into the next call when there is no gap.
	task automatic send_byte(input byte_t b);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		absorb_rx_byte(b);
	endtask

	task automatic send_bytes(input byte_queue_t bytes);
		foreach (bytes[i])
			send_byte(bytes[i]);
		frame_bytes_sent += bytes.size();
	endtask

	// Sync, length, id and payload, then a checksum that zeroes the XOR unless corrupted.
	// A length that does not fit yields only the sync and length bytes.
	function automatic byte_queue_t make_frame(input byte_t sync, input byte_t len,
			input bit corrupt);
		byte_queue_t bytes;
		byte_t       sum;
		byte_t       b;
		bytes.push_back(sync);
		bytes.push_back(len);
		if (int'(len) + FRAME_OVERHEAD >= BUFFER_BYTES)
			return bytes;
		sum = sync ^ len;
		for (int i = 0; i <= int'(len); i++) begin
			b = byte_t'($urandom_range(0, 255));
			sum ^= b;
			bytes.push_back(b);
		end
		if (corrupt)
			sum ^= byte_t'($urandom_range(1, 255));
		bytes.push_back(sum);
		return bytes;
	endfunction

	// Mostly short frames, with the largest length and lengths that do not fit now and then.
	function automatic byte_t pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return byte_t'(BUFFER_BYTES - FRAME_OVERHEAD - 1);
		if (r == 2)
			return byte_t'($urandom_range(BUFFER_BYTES - FRAME_OVERHEAD, 255));
		if (r < 6)
			return byte_t'($urandom_range(11, BUFFER_BYTES - FRAME_OVERHEAD - 2));
		return byte_t'($urandom_range(0, 10));
	endfunction

	// Register writes happen only once the block has drained.
	task automatic write_sync(input byte_t value);
		in_valid <= 1'b0;
		while (expected_frame_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		track_sync = value;
	endtask

	// Noise while hunting, shortest frame good and bad, the smallest length that does not fit the buffer.
	task automatic test_directed_cases();
		byte_queue_t bytes;
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_bytes(make_frame(track_sync, 8'd0, 1'b0));
		send_bytes(make_frame(track_sync, 8'd0, 1'b1));
		send_bytes(make_frame(track_sync, byte_t'(BUFFER_BYTES - FRAME_OVERHEAD), 1'b0));
		// A sync-valued length byte that does not fit starts a new frame.
		bytes = make_frame(track_sync, 8'd1, 1'b0);
		bytes.push_front(track_sync);
		send_bytes(bytes);
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames.
	task automatic test_random_traffic(input int budget);
		byte_queue_t bytes;
		int          r;
		int          cut;
		while (frame_bytes_sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_bytes(make_frame(track_sync, pick_length(), 1'b0));
			end else if (r < 80) begin
				send_bytes(make_frame(track_sync, pick_length(), 1'b1));
			end else if (r < 88) begin
				// Truncated frame; the next frame is read as its continuation.
				bytes = make_frame(track_sync, pick_length(), 1'b0);
				cut = $urandom_range(1, bytes.size() - 1);
				bytes = bytes[0:cut - 1];
				send_bytes(bytes);
			end else if (r < 94) begin
				repeat ($urandom_range(1, 4))
					send_byte(byte_t'($urandom_range(0, 255)));
			end else begin
				bytes = make_frame(track_sync, pick_length(), 1'b0);
				bytes.push_front(track_sync);
				send_bytes(bytes);
			end
		end
	endtask

	// The receiver holds off for a long stretch while frames keep arriving back to back.
	task automatic test_output_holdoff(input int budget);
		sender_gaps = 1'b0;
		hold_off_request = 1'b1;
		while (frame_bytes_sent < budget)
			send_bytes(make_frame(track_sync, byte_t'($urandom_range(6, 14)), 1'b0));
		sender_gaps = 1'b1;
	endtask

	// The sync register at its extremes and at a random value.
	task automatic test_sync_settings();
		write_sync(8'h00);
		frame_bytes_sent = 0;
		test_random_traffic(60);
		write_sync(8'hFF);
		frame_bytes_sent = 0;
		test_random_traffic(60);
		write_sync(byte_t'($urandom_range(0, 255)));
		frame_bytes_sent = 0;
		test_random_traffic(60);
		write_sync(SYNC_RESET);
		frame_bytes_sent = 0;
		test_random_traffic(20);
	endtask

	// Output side: random stalls, ready stretches, and the long hold-off on request.
	initial begin : drive_out_ready
		int held;
		out_ready = 1'b0;
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Compare each output transfer with the oldest expected frame byte.
	always @(posedge clk) begin : check_frame_output
		frame_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frame_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected frame byte %h last %b",
					frame_byte, frame_last));
			end else begin
				want = expected_frame_bytes.pop_front();
				if (frame_byte !== want.data)
					report_mismatch($sformatf("frame_byte %h, expected %h",
						frame_byte, want.data));
				if (frame_last !== want.last)
					report_mismatch($sformatf("frame_last %b, expected %b on byte %h",
						frame_last, want.last, want.data));
			end
		end
	end

	// Main sequence.
	initial begin
		int waited;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		mismatch_count = 0;
		frame_bytes_sent = 0;
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		hold_off_request = 1'b0;
		track_sync = SYNC_RESET;
		track_index = 0;
		track_final = 2;
		track_xor = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		frame_bytes_sent = 0;
		test_random_traffic(60);
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		frame_bytes_sent = 0;
		test_random_traffic(100);
		frame_bytes_sent = 0;
		test_output_holdoff(40);
		test_sync_settings();

		// Drain whatever is still expected, then let the block settle.
		in_valid <= 1'b0;
		for (waited = 0; waited < DRAIN_LIMIT && expected_frame_bytes.size() != 0; waited++)
			@(posedge clk);
		if (expected_frame_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected frame bytes never arrived",
				expected_frame_bytes.size()));
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
